FILE: rtl/core/astm_pkg.sv
// ----------------------------------------------------------------------------
// astm_pkg
// Shared types and constants of the affine span texture mapper: tile geometry,
// item codes and the request and response beat layouts.
// ----------------------------------------------------------------------------
package astm_pkg;

   localparam int TILE_SIDE_LOG2 = 6;
   localparam int TILE_IDX_W     = 2 * TILE_SIDE_LOG2;
   localparam int TILE_DEPTH     = 1 << TILE_IDX_W;
   localparam int FRAC_BITS      = 16;
   localparam int LIGHT_IDX_W    = 8;
   localparam int LIGHT_DEPTH    = 1 << LIGHT_IDX_W;
   localparam int PIXEL_W        = 8;
   localparam int COORD_W        = 32;
   localparam int COL_W          = 10;
   localparam int ROW_W          = 8;
   localparam int LOAD_IDX_W     = 12;

   typedef enum logic [1:0] {
      CMD_LOAD_TEXEL = 2'd0,
      CMD_LOAD_LIGHT = 2'd1,
      CMD_START_SPAN = 2'd2,
      CMD_DRAW_PIXEL = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic signed [COORD_W-1:0]   u_start;
      logic signed [COORD_W-1:0]   v_start;
      logic signed [COORD_W-1:0]   u_step;
      logic signed [COORD_W-1:0]   v_step;
      logic [COL_W-1:0]            x_first;
      logic [COL_W-1:0]            x_final;
      logic [ROW_W-1:0]            row_y;
      logic [LOAD_IDX_W-1:0]       load_index;
      logic [PIXEL_W-1:0]          load_value;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]       screen_x;
      logic [ROW_W-1:0]       screen_y;
      logic [TILE_IDX_W-1:0]  texel_index;
      logic [PIXEL_W-1:0]     color;
      logic                   span_last;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0]       screen_x;
      logic [ROW_W-1:0]       screen_y;
      logic [TILE_IDX_W-1:0]  texel_index;
      logic                   span_last;
   } pix_meta_type;

endpackage

FILE: rtl/core/astm_ram.sv
// ----------------------------------------------------------------------------
// astm_ram
// Generic single-write, single-read synchronous RAM. The read is registered,
// returns the old contents on a same-address write, and holds while rd_en is
// low.
// ----------------------------------------------------------------------------
module astm_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/affine_span_texture_mapper.sv
// ----------------------------------------------------------------------------
// affine_span_texture_mapper
// Draws one horizontal span by affine texture mapping from a square texel
// tile through a light colormap.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock while req_stall is low. Load beats
// write the tile or colormap RAM at once, start beats latch the span, and each
// draw beat inside the span yields one response beat: the tile RAM read and
// the dependent colormap RAM read are each registered, followed by the output
// register. Draw beats past the span end give no response. A stalled response
// backs up the pipeline one stage at a time.
module affine_span_texture_mapper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  astm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output astm_pkg::rsp_type rsp_data
);

   localparam int L  = astm_pkg::TILE_SIDE_LOG2;
   localparam int FB = astm_pkg::FRAC_BITS;

   logic [astm_pkg::COORD_W-1:0] u_accum_ff, u_accum_in;
   logic [astm_pkg::COORD_W-1:0] v_accum_ff, v_accum_in;
   logic [astm_pkg::COORD_W-1:0] u_delta_ff, u_delta_in;
   logic [astm_pkg::COORD_W-1:0] v_delta_ff, v_delta_in;
   logic [astm_pkg::COL_W:0]     cur_col_ff, cur_col_in;
   logic [astm_pkg::COL_W-1:0]   end_col_ff, end_col_in;
   logic [astm_pkg::ROW_W-1:0]   cur_row_ff, cur_row_in;

   logic                   valid1_ff, valid1_in;
   logic                   valid2_ff, valid2_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   astm_pkg::pix_meta_type meta1_ff, meta1_in;
   astm_pkg::pix_meta_type meta2_ff, meta2_in;
   astm_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic ready_out, ready2, ready1;
   logic accept, draw_go, span_active;
   logic tile_wr, light_wr;
   logic [astm_pkg::TILE_IDX_W-1:0] texel_idx;
   logic [astm_pkg::PIXEL_W-1:0]    texel_data;
   logic [astm_pkg::PIXEL_W-1:0]    color_data;

   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !valid2_ff || ready_out;
   assign ready1    = !valid1_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;

   assign span_active = cur_col_ff <= {1'b0, end_col_ff};
   assign texel_idx   = {v_accum_ff[FB+L-1:FB], u_accum_ff[FB+L-1:FB]};

   always_comb begin
      u_accum_in = u_accum_ff;
      v_accum_in = v_accum_ff;
      u_delta_in = u_delta_ff;
      v_delta_in = v_delta_ff;
      cur_col_in = cur_col_ff;
      end_col_in = end_col_ff;
      cur_row_in = cur_row_ff;
      tile_wr    = 1'b0;
      light_wr   = 1'b0;
      draw_go    = 1'b0;
      if (accept) begin
         unique case (req_data.cmd)
            astm_pkg::CMD_LOAD_TEXEL: begin
               tile_wr = 1'b1;
            end
            astm_pkg::CMD_LOAD_LIGHT: begin
               light_wr = 1'b1;
            end
            astm_pkg::CMD_START_SPAN: begin
               u_accum_in = req_data.u_start;
               v_accum_in = req_data.v_start;
               u_delta_in = req_data.u_step;
               v_delta_in = req_data.v_step;
               cur_col_in = {1'b0, req_data.x_first};
               end_col_in = req_data.x_final;
               cur_row_in = req_data.row_y;
            end
            astm_pkg::CMD_DRAW_PIXEL: begin
               if (span_active) begin
                  draw_go    = 1'b1;
                  u_accum_in = u_accum_ff + u_delta_ff;
                  v_accum_in = v_accum_ff + v_delta_ff;
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      valid1_in    = valid1_ff;
      valid2_in    = valid2_ff;
      rsp_valid_in = rsp_valid_ff;
      meta1_in     = meta1_ff;
      meta2_in     = meta2_ff;
      rsp_data_in  = rsp_data_ff;
      if (ready1) begin
         valid1_in            = draw_go;
         meta1_in.screen_x    = cur_col_ff[astm_pkg::COL_W-1:0];
         meta1_in.screen_y    = cur_row_ff;
         meta1_in.texel_index = texel_idx;
         meta1_in.span_last   = cur_col_ff == {1'b0, end_col_ff};
      end
      if (ready2) begin
         valid2_in = valid1_ff;
         meta2_in  = meta1_ff;
      end
      if (ready_out) begin
         rsp_valid_in            = valid2_ff;
         rsp_data_in.screen_x    = meta2_ff.screen_x;
         rsp_data_in.screen_y    = meta2_ff.screen_y;
         rsp_data_in.texel_index = meta2_ff.texel_index;
         rsp_data_in.span_last   = meta2_ff.span_last;
         rsp_data_in.color       = color_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_accum_ff   <= '0;
         v_accum_ff   <= '0;
         u_delta_ff   <= '0;
         v_delta_ff   <= '0;
         cur_col_ff   <= '0;
         end_col_ff   <= '0;
         cur_row_ff   <= '0;
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         u_accum_ff   <= u_accum_in;
         v_accum_ff   <= v_accum_in;
         u_delta_ff   <= u_delta_in;
         v_delta_ff   <= v_delta_in;
         cur_col_ff   <= cur_col_in;
         end_col_ff   <= end_col_in;
         cur_row_ff   <= cur_row_in;
         valid1_ff    <= valid1_in;
         valid2_ff    <= valid2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta1_ff    <= meta1_in;
      meta2_ff    <= meta2_in;
      rsp_data_ff <= rsp_data_in;
   end

   astm_ram #(
      .DATA_W(astm_pkg::PIXEL_W),
      .DEPTH (astm_pkg::TILE_DEPTH)
   ) u_tile_ram (
      .clock  (clock),
      .wr_en  (tile_wr),
      .wr_addr(req_data.load_index[astm_pkg::TILE_IDX_W-1:0]),
      .wr_data(req_data.load_value),
      .rd_en  (draw_go),
      .rd_addr(texel_idx),
      .rd_data(texel_data)
   );

   astm_ram #(
      .DATA_W(astm_pkg::PIXEL_W),
      .DEPTH (astm_pkg::LIGHT_DEPTH)
   ) u_light_ram (
      .clock  (clock),
      .wr_en  (light_wr),
      .wr_addr(req_data.load_index[astm_pkg::LIGHT_IDX_W-1:0]),
      .wr_data(req_data.load_value),
      .rd_en  (ready2 && valid1_ff),
      .rd_addr(texel_data),
      .rd_data(color_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/affine_span_texture_mapper_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_span_texture_mapper_test
// Self-checking bench for the affine span texture mapper. A stimulus process
// loads texels and colormap entries, then starts spans and draws their pixels.
// A directed opening covers the extremes and corner cases, and random spans
// follow. Every draw reads only tile and colormap entries that were loaded
// before it. Accepted request beats go through a behavioral model of the
// mapper, and each response beat is checked field by field against the
// oldest predicted pixel. Both channels idle and stall at random, the
// receiver holds off once for a long stretch, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module affine_span_texture_mapper_test;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int ITEMS_PER_PART = 350;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   astm_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   astm_pkg::rsp_type rsp_data;

   affine_span_texture_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   astm_pkg::req_type span_beat_q[$];
   astm_pkg::rsp_type pixel_expect_q[$];

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int error_count   = 0;
   int item_count    = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   bit hold_request  = 1'b0;
   bit hold_seen     = 1'b0;

   // Model of the mapper, advanced on each accepted request beat.
   logic [astm_pkg::COORD_W-1:0] span_u   = '0;
   logic [astm_pkg::COORD_W-1:0] span_v   = '0;
   logic [astm_pkg::COORD_W-1:0] span_du  = '0;
   logic [astm_pkg::COORD_W-1:0] span_dv  = '0;
   logic [astm_pkg::COL_W:0]     span_col = '0;
   logic [astm_pkg::COL_W-1:0]   span_end = '0;
   logic [astm_pkg::ROW_W-1:0]   span_row = '0;
   logic [astm_pkg::PIXEL_W-1:0] tile_ram  [astm_pkg::TILE_DEPTH];
   logic [astm_pkg::PIXEL_W-1:0] light_ram [astm_pkg::LIGHT_DEPTH];

   // Planning copy of the span cursor and of what has been loaded, so that
   // the stimulus never makes the mapper read an unwritten entry.
   logic [astm_pkg::COORD_W-1:0] plan_u   = '0;
   logic [astm_pkg::COORD_W-1:0] plan_v   = '0;
   logic [astm_pkg::COORD_W-1:0] plan_du  = '0;
   logic [astm_pkg::COORD_W-1:0] plan_dv  = '0;
   logic [astm_pkg::COL_W:0]     plan_col = '0;
   logic [astm_pkg::COL_W-1:0]   plan_end = '0;
   bit                           texel_loaded [astm_pkg::TILE_DEPTH];
   logic [astm_pkg::PIXEL_W-1:0] texel_plan   [astm_pkg::TILE_DEPTH];
   bit                           shade_loaded [astm_pkg::LIGHT_DEPTH];

   function automatic logic [astm_pkg::TILE_IDX_W-1:0] tile_addr(
         input logic [astm_pkg::COORD_W-1:0] u,
         input logic [astm_pkg::COORD_W-1:0] v);
      return {v[astm_pkg::FRAC_BITS +: astm_pkg::TILE_SIDE_LOG2],
              u[astm_pkg::FRAC_BITS +: astm_pkg::TILE_SIDE_LOG2]};
   endfunction

   task automatic predict_beat(input astm_pkg::req_type r);
      astm_pkg::rsp_type               px;
      logic [astm_pkg::TILE_IDX_W-1:0] a;
      case (r.cmd)
         astm_pkg::CMD_LOAD_TEXEL:
            tile_ram[r.load_index[astm_pkg::TILE_IDX_W-1:0]] = r.load_value;
         astm_pkg::CMD_LOAD_LIGHT:
            light_ram[r.load_index[astm_pkg::LIGHT_IDX_W-1:0]] = r.load_value;
         astm_pkg::CMD_START_SPAN: begin
            span_u   = r.u_start;
            span_v   = r.v_start;
            span_du  = r.u_step;
            span_dv  = r.v_step;
            span_col = {1'b0, r.x_first};
            span_end = r.x_final;
            span_row = r.row_y;
         end
         default: begin
            if (span_col <= {1'b0, span_end}) begin
               a              = tile_addr(span_u, span_v);
               px.screen_x    = span_col[astm_pkg::COL_W-1:0];
               px.screen_y    = span_row;
               px.texel_index = a;
               px.color       = light_ram[tile_ram[a]];
               px.span_last   = (span_col == {1'b0, span_end});
               pixel_expect_q.push_back(px);
               span_u   = span_u + span_du;
               span_v   = span_v + span_dv;
               span_col = span_col + 1'b1;
            end
         end
      endcase
   endtask

   function automatic astm_pkg::req_type random_req();
      astm_pkg::req_type r;
      r.cmd        = astm_pkg::cmd_type'($urandom_range(3));
      r.u_start    = $urandom;
      r.v_start    = $urandom;
      r.u_step     = $urandom;
      r.v_step     = $urandom;
      r.x_first    = astm_pkg::COL_W'($urandom_range(1023));
      r.x_final    = astm_pkg::COL_W'($urandom_range(1023));
      r.row_y      = astm_pkg::ROW_W'($urandom_range(255));
      r.load_index = astm_pkg::LOAD_IDX_W'($urandom_range(4095));
      r.load_value = astm_pkg::PIXEL_W'($urandom_range(255));
      return r;
   endfunction

   function automatic logic [astm_pkg::COORD_W-1:0] random_step();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h3FFFF) - 32'h20000;
         2: return '0;
         default: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      endcase
   endfunction

   task automatic queue_item(input astm_pkg::req_type r);
      case (r.cmd)
         astm_pkg::CMD_LOAD_TEXEL: begin
            texel_loaded[r.load_index[astm_pkg::TILE_IDX_W-1:0]] = 1'b1;
            texel_plan[r.load_index[astm_pkg::TILE_IDX_W-1:0]]   = r.load_value;
         end
         astm_pkg::CMD_LOAD_LIGHT:
            shade_loaded[r.load_index[astm_pkg::LIGHT_IDX_W-1:0]] = 1'b1;
         astm_pkg::CMD_START_SPAN: begin
            plan_u   = r.u_start;
            plan_v   = r.v_start;
            plan_du  = r.u_step;
            plan_dv  = r.v_step;
            plan_col = {1'b0, r.x_first};
            plan_end = r.x_final;
         end
         default: begin
            if (plan_col <= {1'b0, plan_end}) begin
               plan_u   = plan_u + plan_du;
               plan_v   = plan_v + plan_dv;
               plan_col = plan_col + 1'b1;
            end
         end
      endcase
      span_beat_q.push_back(r);
      item_count++;
   endtask

   // A draw that will emit a pixel is preceded by whatever loads it needs.
   task automatic queue_draw();
      astm_pkg::req_type               r;
      logic [astm_pkg::TILE_IDX_W-1:0] a;
      if (plan_col <= {1'b0, plan_end}) begin
         a = tile_addr(plan_u, plan_v);
         if (!texel_loaded[a]) begin
            r            = random_req();
            r.cmd        = astm_pkg::CMD_LOAD_TEXEL;
            r.load_index = a;
            queue_item(r);
         end
         if (!shade_loaded[texel_plan[a]]) begin
            r     = random_req();
            r.cmd = astm_pkg::CMD_LOAD_LIGHT;
            r.load_index[astm_pkg::LIGHT_IDX_W-1:0] = texel_plan[a];
            queue_item(r);
         end
      end
      r     = random_req();
      r.cmd = astm_pkg::CMD_DRAW_PIXEL;
      queue_item(r);
   endtask

   task automatic queue_start(input logic [astm_pkg::COORD_W-1:0] u,
                              input logic [astm_pkg::COORD_W-1:0] v,
                              input logic [astm_pkg::COORD_W-1:0] du,
                              input logic [astm_pkg::COORD_W-1:0] dv,
                              input logic [astm_pkg::COL_W-1:0]   x_lo,
                              input logic [astm_pkg::COL_W-1:0]   x_hi,
                              input logic [astm_pkg::ROW_W-1:0]   row);
      astm_pkg::req_type r;
      r         = random_req();
      r.cmd     = astm_pkg::CMD_START_SPAN;
      r.u_start = u;
      r.v_start = v;
      r.u_step  = du;
      r.v_step  = dv;
      r.x_first = x_lo;
      r.x_final = x_hi;
      r.row_y   = row;
      queue_item(r);
   endtask

   task automatic queue_span();
      int                shape;
      int                x_lo;
      int                x_hi;
      int                len;
      int                draws;
      astm_pkg::req_type r;
      shape = $urandom_range(15);
      if (shape == 0) begin
         x_lo  = $urandom_range(1023, 1);
         x_hi  = $urandom_range(x_lo - 1, 0);
         draws = $urandom_range(2, 1);
      end else begin
         len   = (shape == 1) ? $urandom_range(64, 1) : $urandom_range(12, 1);
         x_lo  = (shape == 2) ? 1024 - $urandom_range(12, 1) : $urandom_range(1023);
         x_hi  = (x_lo + len - 1 > 1023) ? 1023 : x_lo + len - 1;
         draws = x_hi - x_lo + 1 + $urandom_range(2);
         if (shape == 3)
            draws = $urandom_range(x_hi - x_lo);
      end
      queue_start($urandom, $urandom, random_step(), random_step(),
                  x_lo[astm_pkg::COL_W-1:0], x_hi[astm_pkg::COL_W-1:0],
                  astm_pkg::ROW_W'($urandom_range(255)));
      repeat (draws) begin
         if ($urandom_range(7) == 0) begin
            r = random_req();
            case ($urandom_range(2))
               0: r.cmd = astm_pkg::CMD_LOAD_TEXEL;
               1: r.cmd = astm_pkg::CMD_LOAD_LIGHT;
               default: r.cmd = astm_pkg::CMD_START_SPAN;
            endcase
            queue_item(r);
         end
         queue_draw();
      end
   endtask

   task automatic wait_until_drained();
      while (span_beat_q.size() != 0 || req_valid || pixel_expect_q.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_beats
      logic              next_valid;
      astm_pkg::req_type next_data;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_beat(req_data);
            next_valid = 1'b0;
         end
         if (!next_valid && span_beat_q.size() != 0 &&
             $urandom_range(99) >= tx_idle_pct) begin
            next_valid = 1'b1;
            next_data  = span_beat_q.pop_front();
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   always @(posedge clock) begin : check_pixels
      astm_pkg::rsp_type px;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_expect_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected pixel beat: x=%0d y=%0d idx=%0d color=%0d last=%0b",
                           rsp_data.screen_x, rsp_data.screen_y, rsp_data.texel_index,
                           rsp_data.color, rsp_data.span_last);
            end else begin
               px = pixel_expect_q.pop_front();
               if (rsp_data.screen_x !== px.screen_x || rsp_data.screen_y !== px.screen_y ||
                   rsp_data.texel_index !== px.texel_index || rsp_data.color !== px.color ||
                   rsp_data.span_last !== px.span_last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $write("pixel mismatch: expected x=%0d y=%0d idx=%0d color=%0d last=%0b",
                            px.screen_x, px.screen_y, px.texel_index, px.color,
                            px.span_last);
                     $display(", got x=%0d y=%0d idx=%0d color=%0d last=%0b",
                              rsp_data.screen_x, rsp_data.screen_y,
                              rsp_data.texel_index, rsp_data.color, rsp_data.span_last);
                  end
               end
            end
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      astm_pkg::req_type r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      tx_idle_pct = 20;
      rx_idle_pct = 77;

      // Draw straight after reset: a one-pixel span at column 0, then past its end.
      queue_draw();
      queue_draw();
      // Loads at the index extremes, including a colormap load index above 255, which wraps to entry 255.
      r            = random_req();
      r.cmd        = astm_pkg::CMD_LOAD_TEXEL;
      r.load_index = 12'hFFF;
      r.load_value = 8'hFF;
      queue_item(r);
      r.load_index = 12'h000;
      r.load_value = 8'h00;
      queue_item(r);
      r.cmd        = astm_pkg::CMD_LOAD_LIGHT;
      r.load_index = 12'hFFF;
      r.load_value = 8'hFF;
      queue_item(r);
      r.load_index = 12'h000;
      r.load_value = 8'h00;
      queue_item(r);
      // Span ending at column 1023 with coordinates and steps at their extremes.
      queue_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  10'd1021, 10'd1023, 8'd255);
      repeat (4) queue_draw();
      queue_start(32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 10'd0, 8'd0);
      repeat (2) queue_draw();
      // Empty span: the last column lies below the first.
      queue_start(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1, 10'd1023, 10'd0, 8'd17);
      repeat (2) queue_draw();
      queue_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                  10'd500, 10'd503, 8'd128);
      repeat (5) queue_draw();

      while (item_count < ITEMS_PER_PART) queue_span();
      wait_until_drained();

      @(negedge clock);
      tx_idle_pct = 77;
      rx_idle_pct = 20;
      while (item_count < 2 * ITEMS_PER_PART) queue_span();
      wait_until_drained();

      @(negedge clock);
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      hold_request = ~hold_request;
      while (item_count < 3 * ITEMS_PER_PART) queue_span();
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pixel_expect_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
